// ----- hdl/cfd_pkg.sv -----
// Shared types and constants for the coordinate frame decoder.
// Used by cfd_in_stage, cfd_parser and coordinate_frame_decoder_unit; no dependencies.
`default_nettype none

package cfd_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int REPORT_WIDTH = 32;
	localparam int PAYLOAD_BYTES = 6;
	localparam int INDEX_WIDTH = 3;

	localparam logic [7:0] SYNC_FIRST = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'hBB;
	localparam logic [15:0] COORD_ABSENT = 16'hFFFF;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;
	typedef logic [REPORT_WIDTH-1:0] report_t;
	typedef logic [INDEX_WIDTH-1:0] index_t;

	// One byte held in the input register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} cfd_beat_t;

	// Reports the low bits of a running count, zero-extended when the count is narrower.
	function automatic report_t report_count(cnt_t c);
		logic [63:0] wide;
		wide = 64'(c);
		return wide[REPORT_WIDTH-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cfd_in_stage.sv -----
// Input register of the coordinate frame decoder: holds one received byte.
// Depends on cfd_pkg.
`default_nettype none

module cfd_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              take,
	output cfd_pkg::cfd_beat_t     beat_s1
);
	import cfd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;

	// The register may refill in the same cycle that the parser empties it.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= rx_byte;
		end
	end

	assign beat_s1.valid = valid_s1;
	assign beat_s1.data = data_s1;

endmodule

`default_nettype wire

// ----- hdl/cfd_parser.sv -----
// Frame parser: sync hunt, payload capture, checksum and counters, with the result register.
// Depends on cfd_pkg.
`default_nettype none

module cfd_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cfd_pkg::cfd_beat_t  beat_s1,
	output logic                     take,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     frame_good,
	output logic signed [15:0]       coord_x,
	output logic signed [15:0]       coord_y,
	output logic signed [15:0]       coord_z,
	output logic                     target_present,
	output cfd_pkg::report_t         good_frame_count,
	output cfd_pkg::report_t         bad_frame_count,
	output cfd_pkg::report_t         byte_count
);
	import cfd_pkg::*;

	typedef enum logic [1:0] {
		PHASE_HUNT,
		PHASE_PAIR,
		PHASE_BODY
	} phase_t;

	phase_t     phase_q;
	index_t     idx_q;
	logic [7:0] xor_q;
	logic [7:0] payload_q [PAYLOAD_BYTES];
	cnt_t       good_q;
	cnt_t       bad_q;
	cnt_t       bytes_q;
	logic       out_valid_q;

	logic       at_checksum;
	logic       is_result;
	logic       good;
	cnt_t       bytes_next;
	cnt_t       good_next;
	cnt_t       bad_next;
	logic [15:0] x_w;
	logic [15:0] y_w;
	logic [15:0] z_w;

	assign at_checksum = (phase_q == PHASE_BODY) && (idx_q >= index_t'(PAYLOAD_BYTES));
	assign is_result = beat_s1.valid && at_checksum;
	// A byte that yields no result never waits on the output side.
	assign take = beat_s1.valid && (!at_checksum || !out_valid_q || out_ready);

	assign good = (beat_s1.data == xor_q);
	assign bytes_next = bytes_q + cnt_t'(1);
	assign good_next = good ? good_q + cnt_t'(1) : good_q;
	assign bad_next = good ? bad_q : bad_q + cnt_t'(1);
	assign x_w = {payload_q[1], payload_q[0]};
	assign y_w = {payload_q[3], payload_q[2]};
	assign z_w = {payload_q[5], payload_q[4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_HUNT;
			idx_q <= '0;
			xor_q <= '0;
			good_q <= '0;
			bad_q <= '0;
			bytes_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may load in the same cycle that the old one drains.
			if (take && is_result) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				bytes_q <= bytes_next;
				unique case (phase_q)
					PHASE_PAIR: begin
						if (beat_s1.data == SYNC_SECOND) begin
							phase_q <= PHASE_BODY;
							idx_q <= '0;
							xor_q <= SYNC_FIRST ^ SYNC_SECOND;
						end else if (beat_s1.data != SYNC_FIRST) begin
							phase_q <= PHASE_HUNT;
						end
					end
					PHASE_BODY: begin
						if (!at_checksum) begin
							xor_q <= xor_q ^ beat_s1.data;
							idx_q <= idx_q + index_t'(1);
						end else begin
							phase_q <= PHASE_HUNT;
							idx_q <= '0;
							good_q <= good_next;
							bad_q <= bad_next;
						end
					end
					default: begin
						phase_q <= (beat_s1.data == SYNC_FIRST) ? PHASE_PAIR : PHASE_HUNT;
					end
				endcase
			end
		end
	end

	// Payload bytes and result fields carry no reset.
	always_ff @(posedge clk) begin
		if (take && (phase_q == PHASE_BODY) && !at_checksum) begin
			payload_q[idx_q] <= beat_s1.data;
		end
		if (take && is_result) begin
			frame_good <= good;
			coord_x <= good ? x_w : '0;
			coord_y <= good ? y_w : '0;
			coord_z <= good ? z_w : '0;
			target_present <= good && !((x_w == COORD_ABSENT) && (y_w == COORD_ABSENT)
				&& (z_w == COORD_ABSENT));
			good_frame_count <= report_count(good_next);
			bad_frame_count <= report_count(bad_next);
			byte_count <= report_count(bytes_next);
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PHASE_BODY) |-> (idx_q <= index_t'(PAYLOAD_BYTES)))
		else $error("payload index beyond checksum position");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_result) |=> out_valid_q)
		else $error("checksum byte taken without a result");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !frame_good) |->
		(coord_x == '0 && coord_y == '0 && coord_z == '0 && !target_present))
		else $error("bad frame carries coordinates");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(take && is_result))
		else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- hdl/coordinate_frame_decoder_unit.sv -----
// Coordinate frame decoder, top level: input register feeding the frame parser.
// Depends on cfd_pkg, cfd_in_stage and cfd_parser.
`default_nettype none

// Takes one received byte per cycle and hunts for the sync pair 0xAA 0xBB, then six payload
// bytes and a checksum byte (XOR of the eight bytes before it). Each completed frame gives one
// result beat: the checksum verdict, three little-endian signed coordinates (zero on a bad
// frame), a target flag that is low for (-1,-1,-1), and running good-frame, bad-frame and byte
// counts. A byte is taken every cycle while results are being drained; a result is offered
// once its checksum byte has passed through the input register and into the result register.
// Only a checksum byte ever waits on a stalled result. No clearing pass follows reset.
module coordinate_frame_decoder_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       rx_byte,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  frame_good,
	output logic signed [15:0]    coord_x,
	output logic signed [15:0]    coord_y,
	output logic signed [15:0]    coord_z,
	output logic                  target_present,
	output cfd_pkg::report_t      good_frame_count,
	output cfd_pkg::report_t      bad_frame_count,
	output cfd_pkg::report_t      byte_count
);
	import cfd_pkg::*;

	cfd_beat_t beat_s1;
	logic      take;

	cfd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.take     (take),
		.beat_s1  (beat_s1)
	);

	cfd_parser u_parser (
		.clk              (clk),
		.arst_n           (arst_n),
		.beat_s1          (beat_s1),
		.take             (take),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.frame_good       (frame_good),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.coord_z          (coord_z),
		.target_present   (target_present),
		.good_frame_count (good_frame_count),
		.bad_frame_count  (bad_frame_count),
		.byte_count       (byte_count)
	);

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for coordinate_frame_decoder_unit: drives received bytes, predicts
// each frame report from its own decoder copy and compares every result beat field by field.
// Depends on cfd_pkg and the RTL of coordinate_frame_decoder_unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cfd_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [1:0] {PH_HUNT, PH_PAIR, PH_BODY} sync_phase_t;

	typedef struct packed {
		logic               good;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               present;
		report_t            good_cnt;
		report_t            bad_cnt;
		report_t            byte_cnt;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic frame_good;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic signed [15:0] coord_z;
	logic target_present;
	report_t good_frame_count;
	report_t bad_frame_count;
	report_t byte_count;

	// Decoder state as the testbench sees it.
	sync_phase_t rx_phase = PH_HUNT;
	index_t body_index = '0;
	logic [7:0] body_bytes [PAYLOAD_BYTES];
	logic [7:0] body_xor = '0;
	cnt_t frames_ok = '0;
	cnt_t frames_corrupt = '0;
	cnt_t bytes_seen = '0;

	frame_report_t pending_reports [$];
	frame_report_t predicted;
	frame_report_t wanted;
	frame_report_t seen;

	int mismatches = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	int hold_len = 0;
	bit src_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;

	coordinate_frame_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_good(frame_good),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.target_present(target_present),
		.good_frame_count(good_frame_count),
		.bad_frame_count(bad_frame_count),
		.byte_count(byte_count)
	);

	always #5 clk = ~clk;

	// Advances the decoder copy by one byte; returns 1 when the byte completes a frame.
	function automatic bit advance_decoder(input logic [7:0] b, output frame_report_t r);
		bit done;
		done = 1'b0;
		r = '0;
		bytes_seen = bytes_seen + cnt_t'(1);
		if (rx_phase == PH_PAIR) begin
			if (b == SYNC_SECOND) begin
				rx_phase = PH_BODY;
				body_index = '0;
				body_xor = SYNC_FIRST ^ SYNC_SECOND;
			end else if (b != SYNC_FIRST) begin
				rx_phase = PH_HUNT;
			end
		end else if (rx_phase != PH_BODY) begin
			rx_phase = (b == SYNC_FIRST) ? PH_PAIR : PH_HUNT;
		end else if (body_index < index_t'(PAYLOAD_BYTES)) begin
			body_bytes[body_index] = b;
			body_xor = body_xor ^ b;
			body_index = body_index + index_t'(1);
		end else begin
			rx_phase = PH_HUNT;
			body_index = '0;
			done = 1'b1;
			r.good = (b == body_xor);
			if (r.good) begin
				frames_ok = frames_ok + cnt_t'(1);
				r.x = {body_bytes[1], body_bytes[0]};
				r.y = {body_bytes[3], body_bytes[2]};
				r.z = {body_bytes[5], body_bytes[4]};
				r.present = !(r.x == COORD_ABSENT && r.y == COORD_ABSENT
					&& r.z == COORD_ABSENT);
			end else begin
				frames_corrupt = frames_corrupt + cnt_t'(1);
			end
			r.good_cnt = report_count(frames_ok);
			r.bad_cnt = report_count(frames_corrupt);
			r.byte_cnt = report_count(bytes_seen);
		end
		return done;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result side and prediction share one process, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (out_valid && out_ready) begin
				seen.good = frame_good;
				seen.x = coord_x;
				seen.y = coord_y;
				seen.z = coord_z;
				seen.present = target_present;
				seen.good_cnt = good_frame_count;
				seen.bad_cnt = bad_frame_count;
				seen.byte_cnt = byte_count;
				if (pending_reports.size() == 0) begin
					$display("%0t ns: unexpected result beat, expected none, actual %h",
						$time, seen);
					mismatches++;
				end else begin
					wanted = pending_reports.pop_front();
					check_field("frame_good", 32'(wanted.good), 32'(seen.good));
					check_field("coord_x", 32'(wanted.x), 32'(seen.x));
					check_field("coord_y", 32'(wanted.y), 32'(seen.y));
					check_field("coord_z", 32'(wanted.z), 32'(seen.z));
					check_field("target_present", 32'(wanted.present), 32'(seen.present));
					check_field("good_frame_count", wanted.good_cnt, seen.good_cnt);
					check_field("bad_frame_count", wanted.bad_cnt, seen.bad_cnt);
					check_field("byte_count", wanted.byte_cnt, seen.byte_cnt);
				end
			end
			if (in_valid && in_ready) begin
				if (advance_decoder(rx_byte, predicted))
					pending_reports.push_back(predicted);
			end
		end
	end

	// Watchdog: counts cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("coordinate_frame_decoder_unit test failed");
				$finish;
			end
		end
	end

	// Result sink: random stall bursts, plus a long hold when a test requests one.
	initial begin : result_sink
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one byte and returns once it has been accepted; valid stays high afterwards.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (src_idle_en && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// Payload byte 0 sits in the low bits of body.
	task automatic send_frame(input logic [47:0] body, input bit corrupt);
		logic [7:0] sum;
		sum = SYNC_FIRST ^ SYNC_SECOND;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			sum = sum ^ body[8*i +: 8];
			send_byte(body[8*i +: 8]);
		end
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(sum);
	endtask

	// Leans towards the sync values and the extremes so that they turn up inside payloads.
	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 9))
			0: return SYNC_FIRST;
			1: return SYNC_SECOND;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] random_body();
		logic [47:0] v;
		case ($urandom_range(0, 7))
			0: v = '1;
			1: begin
				v = '1;
				v[16*$urandom_range(0, 2) +: 16] = 16'($urandom);
			end
			default: begin
				for (int i = 0; i < PAYLOAD_BYTES; i++)
					v[8*i +: 8] = random_byte();
			end
		endcase
		return v;
	endfunction

	task automatic test_directed();
		// A repeated first sync byte keeps the pair hunt alive; all-ones means no target.
		send_byte(SYNC_FIRST);
		send_frame(48'hFFFF_FFFF_FFFF, 1'b0);
		send_frame(48'h8000_7FFF_0000, 1'b0);
		send_frame(48'h0001_8000_7FFF, 1'b1);
	endtask

	task automatic test_random_traffic(input int target);
		while (bytes_sent < target) begin
			case ($urandom_range(0, 9))
				0: send_byte(random_byte());
				1: begin
					send_byte(SYNC_FIRST);
					send_byte(random_byte());
				end
				2: begin
					send_byte(SYNC_FIRST);
					send_frame(random_body(), $urandom_range(0, 3) == 0);
				end
				default: send_frame(random_body(), $urandom_range(0, 3) == 0);
			endcase
		end
	endtask

	// The sink holds off while frames keep coming, so the checksum beat must stall the input.
	task automatic test_backpressure();
		hold_len = LONG_HOLD;
		repeat (15) send_frame(random_body(), $urandom_range(0, 3) == 0);
	endtask

	task automatic test_steady_stream(input int target);
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		while (bytes_sent < target)
			send_frame(random_body(), $urandom_range(0, 3) == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(1450);
		test_backpressure();
		test_steady_stream(1850);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("coordinate_frame_decoder_unit test passed");
		else
			$display("coordinate_frame_decoder_unit test failed");
		$finish;
	end

endmodule
